// ===== hw/rtl/tsps_pkg.sv =====
// shared types and constants for the ts psi section reassembler
// no dependencies
package tsps_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int STORE_DEPTH  = 4096;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int BODY_BYTES   = PACKET_BYTES - 4;

    localparam logic [7:0]  SYNC_BYTE  = 8'h47;
    localparam logic [7:0]  STUFF_BYTE = 8'hFF;
    localparam logic [12:0] LEN_MAX    = 13'h0FFF;

    // apb byte address of the wanted pid register
    localparam logic [1:0]  REG_WANTED_PID = 2'd0;

    typedef enum logic [2:0] {
        MODE_IGNORE  = 3'd0,
        MODE_AF      = 3'd1,
        MODE_POINTER = 3'd2,
        MODE_PREGION = 3'd3,
        MODE_SCAN    = 3'd4,
        MODE_SHEAD   = 3'd5,
        MODE_SECTION = 3'd6,
        MODE_CONT    = 3'd7
    } t_mode;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic              packet_start;
        logic [ADDR_W-1:0] read_address;
    } t_in_word;

    typedef struct packed {
        logic              section_ready;
        logic [11:0]       section_length;
        logic [7:0]        read_data;
    } t_out_word;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    // 3 plus the 12-bit length field
    function automatic logic [12:0] sect_len(input logic [7:0] b1, input logic [7:0] b2);
        return 13'd3 + {1'b0, b1[3:0], b2};
    endfunction

    function automatic logic len_ok(input logic [12:0] s);
        return (s > 13'd3) && (s <= LEN_MAX);
    endfunction

endpackage

// ===== hw/rtl/ts_psi_section_reassembler_top.sv =====
// top level of the ts psi section reassembler: apb register, handshakes, result pipeline
// depends on tsps_pkg, tsps_parser, tsps_store
//
// Takes one transport stream byte or one store read per word and returns one result word
// for each. Throughput is one word per cycle while the store is not clearing and results
// are taken. Accepted words are registered in stage one, then in the result register
// once stage one advances. All parsing state is updated once per accepted stream byte,
// store bytes 0..2 are kept in flops (multi-byte header writes land there) and the rest
// go through the single write port of a 4096x8 memory with a registered read. After
// reset the memory is cleared one entry a cycle while no word is accepted; apb writes
// are taken throughout. The host reads a section before sending more stream bytes.
module ts_psi_section_reassembler_top
    import tsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] r_pid;
    logic        busy;
    logic        accept;
    logic        step;
    logic        rd_acc;
    logic        s1_adv;
    t_wr_req     wr;
    logic        p_ready;
    logic [11:0] p_len;
    logic [7:0]  b0, b1, b2;
    logic [7:0]  mem_q;
    logic [7:0]  reg_byte;

    // stage one holds the result while the memory read completes
    logic        r_s1_valid;
    logic        r_s1_ready;
    logic [11:0] r_s1_len;
    logic        r_s1_mem;
    logic [7:0]  r_s1_byte;

    logic        r_o_valid;
    t_out_word   r_o_word;

    // register write completes in the access phase
    assign pready = 1'b1;
    assign prdata = {19'b0, r_pid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid <= '0;
        end else if (psel && penable && pwrite && (paddr == REG_WANTED_PID)) begin
            r_pid <= pwdata[12:0];
        end
    end

    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !busy && (!r_s1_valid || s1_adv);
    assign accept     = i_in_valid && o_in_ready;
    assign step       = accept && !i_in_data.kind;
    assign rd_acc     = accept && i_in_data.kind;

    tsps_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_in_data.data_byte),
        .i_start (i_in_data.packet_start),
        .i_pid   (r_pid),
        .o_wr    (wr),
        .o_ready (p_ready),
        .o_len   (p_len),
        .o_b0    (b0),
        .o_b1    (b1),
        .o_b2    (b2)
    );

    tsps_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (rd_acc),
        .i_rd_addr (i_in_data.read_address),
        .o_rd_data (mem_q),
        .o_busy    (busy)
    );

    // low store bytes come from the flops
    always_comb begin
        unique case (i_in_data.read_address)
            ADDR_W'(0): reg_byte = b0;
            ADDR_W'(1): reg_byte = b1;
            ADDR_W'(2): reg_byte = b2;
            default:    reg_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ready <= step && p_ready;
            r_s1_len   <= step ? p_len : 12'd0;
            r_s1_mem   <= i_in_data.kind && (i_in_data.read_address > ADDR_W'(2));
            r_s1_byte  <= i_in_data.kind ? reg_byte : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_word.section_ready  <= r_s1_ready;
            r_o_word.section_length <= r_s1_len;
            r_o_word.read_data      <= r_s1_mem ? mem_q : r_s1_byte;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_word;

endmodule

// ===== hw/rtl/tsps_store.sv =====
// section store memory with clearing pass after reset
// depends on tsps_pkg
module tsps_store
    import tsps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wr_req           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    output logic              o_busy
);

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        r_q;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= 8'h00;
        end else if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
    assign o_busy    = r_busy;

endmodule

// ===== hw/rtl/tsps_parser.sv =====
// packet header parsing and section assembly state
// depends on tsps_pkg; store bytes 0..2 live here, the rest go to tsps_store
module tsps_parser
    import tsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [12:0] i_pid,
    output t_wr_req     o_wr,
    output logic        o_ready,
    output logic [11:0] o_len,
    output logic [7:0]  o_b0,
    output logic [7:0]  o_b1,
    output logic [7:0]  o_b2
);

    logic [11:0] r_filled, n_filled;
    logic [11:0] r_size, n_size;
    logic [3:0]  r_lastcc, n_lastcc;
    logic [7:0]  r_pos, n_pos;
    logic [2:0]  r_flags, n_flags;
    logic [7:0]  r_aflen, n_aflen;
    logic [7:0]  r_pcount, n_pcount;
    t_mode       r_mode, n_mode;
    logic [15:0] r_shadow, n_shadow;
    logic        r_due, n_due;
    logic [3:0]  r_pcc, n_pcc;
    logic [7:0]  r_b0, n_b0, r_b1, n_b1, r_b2, n_b2;
    logic        n_ready;
    logic [11:0] n_len;
    t_wr_req     n_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_size   <= '0;
            r_lastcc <= '0;
            r_pos    <= '0;
            r_flags  <= '0;
            r_aflen  <= '0;
            r_pcount <= '0;
            r_mode   <= MODE_IGNORE;
            r_shadow <= '0;
            r_due    <= 1'b0;
            r_pcc    <= '0;
            r_b0     <= '0;
            r_b1     <= '0;
            r_b2     <= '0;
        end else if (i_step) begin
            r_filled <= n_filled;
            r_size   <= n_size;
            r_lastcc <= n_lastcc;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_aflen  <= n_aflen;
            r_pcount <= n_pcount;
            r_mode   <= n_mode;
            r_shadow <= n_shadow;
            r_due    <= n_due;
            r_pcc    <= n_pcc;
            r_b0     <= n_b0;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
        end
    end

    always_comb begin
        logic        bp;
        logic        cc_ok;
        logic [12:0] s;
        logic [11:0] wa;
        n_filled = r_filled;
        n_size   = r_size;
        n_lastcc = r_lastcc;
        n_pos    = r_pos;
        n_flags  = r_flags;
        n_aflen  = r_aflen;
        n_pcount = r_pcount;
        n_mode   = r_mode;
        n_shadow = r_shadow;
        n_due    = r_due;
        n_pcc    = r_pcc;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_b2     = r_b2;
        n_ready  = 1'b0;
        n_len    = '0;
        n_wr     = '0;
        bp       = 1'b0;
        s        = '0;
        wa       = '0;

        if (i_start) begin
            n_pos = '0;
        end else if (r_pos < 8'(PACKET_BYTES)) begin
            n_pos = r_pos + 8'd1;
        end

        cc_ok = 1'b0;

        if (n_pos >= 8'(PACKET_BYTES)) begin
            // past packet end
        end else if (n_pos == 8'd0) begin
            n_due   = 1'b0;
            n_flags = '0;
            n_mode  = (i_byte == SYNC_BYTE) ? MODE_AF : MODE_IGNORE;
        end else if (r_mode == MODE_IGNORE) begin
            // skip
        end else if (n_pos == 8'd1) begin
            n_shadow = {8'h00, i_byte};
        end else if (n_pos == 8'd2) begin
            if ({r_shadow[4:0], i_byte} != i_pid) begin
                n_mode = MODE_IGNORE;
            end else begin
                n_flags = {2'b00, r_shadow[6]};
            end
        end else if (n_pos == 8'd3) begin
            n_pcc = i_byte[3:0];
            if (!i_byte[4]) begin
                n_mode = MODE_IGNORE;
            end else if (i_byte[5]) begin
                n_flags = n_flags | 3'b010;
                n_mode  = MODE_AF;
            end else begin
                bp = 1'b1;
            end
        end else begin
            cc_ok = ((r_lastcc + 4'd1) == n_pcc);
            unique case (r_mode)
                MODE_AF: begin
                    if (n_pos == 8'd4) begin
                        if (i_byte >= 8'(BODY_BYTES - 1)) begin
                            n_mode = MODE_IGNORE;
                        end else if (i_byte == 8'd0) begin
                            bp = 1'b1;
                        end else begin
                            n_aflen = i_byte;
                        end
                    end else begin
                        n_aflen = r_aflen - 8'd1;
                        if (n_aflen == 8'd0) begin
                            bp = 1'b1;
                        end
                    end
                end
                MODE_POINTER: begin
                    n_due   = 1'b1;
                    n_flags = n_flags & 3'b011;
                    if (i_byte == 8'd0) begin
                        n_mode = MODE_SCAN;
                    end else if (i_byte >= 8'(BODY_BYTES)) begin
                        n_filled = '0;
                        n_mode   = MODE_IGNORE;
                        n_due    = 1'b0;
                    end else if (r_filled != 12'd0) begin
                        if (!cc_ok) begin
                            n_filled = '0;
                            n_mode   = MODE_IGNORE;
                            n_due    = 1'b0;
                        end else begin
                            n_flags  = n_flags | 3'b100;
                            n_pcount = i_byte;
                            n_mode   = MODE_PREGION;
                        end
                    end else begin
                        n_pcount = i_byte;
                        n_mode   = MODE_PREGION;
                    end
                end
                MODE_PREGION: begin
                    if (r_flags[2]) begin
                        wa = n_filled;
                        if (wa == 12'd0) begin
                            n_b0 = i_byte;
                        end else if (wa == 12'd1) begin
                            n_b1 = i_byte;
                        end else if (wa == 12'd2) begin
                            n_b2 = i_byte;
                        end else begin
                            n_wr = '{en: 1'b1, addr: wa, data: i_byte};
                        end
                        n_filled = wa + 12'd1;
                    end
                    n_pcount = r_pcount - 8'd1;
                    if (n_pcount == 8'd0) begin
                        n_mode = MODE_SCAN;
                        if (r_flags[2]) begin
                            n_flags = n_flags & 3'b011;
                            s = {1'b0, n_size};
                            if (n_size == 12'd0) begin
                                s = sect_len(n_b1, n_b2);
                            end
                            if (!len_ok(s)) begin
                                n_filled = '0;
                                n_mode   = MODE_IGNORE;
                                n_due    = 1'b0;
                            end else begin
                                n_size = s[11:0];
                                if (n_size != n_filled) begin
                                    n_filled = '0;
                                    n_mode   = MODE_IGNORE;
                                    n_due    = 1'b0;
                                end else begin
                                    n_filled = '0;
                                    n_ready  = 1'b1;
                                    n_len    = n_size;
                                end
                            end
                        end
                    end
                end
                MODE_SCAN: begin
                    if (i_byte == STUFF_BYTE) begin
                        n_mode = MODE_IGNORE;
                    end else begin
                        n_size   = '0;
                        n_shadow = {i_byte, 8'h00};
                        n_pcount = 8'd1;
                        n_mode   = MODE_SHEAD;
                    end
                end
                MODE_SHEAD: begin
                    if (r_pcount == 8'd1) begin
                        n_shadow = {r_shadow[15:8], i_byte};
                        n_pcount = 8'd2;
                    end else begin
                        s = sect_len(r_shadow[7:0], i_byte);
                        if (!len_ok(s)) begin
                            n_mode = MODE_IGNORE;
                        end else begin
                            n_size   = s[11:0];
                            n_b0     = r_shadow[15:8];
                            n_b1     = r_shadow[7:0];
                            n_b2     = i_byte;
                            n_filled = 12'd3;
                            n_mode   = MODE_SECTION;
                        end
                    end
                end
                MODE_SECTION, MODE_CONT: begin
                    wa = n_filled;
                    if (wa == 12'd0) begin
                        n_b0 = i_byte;
                    end else if (wa == 12'd1) begin
                        n_b1 = i_byte;
                    end else if (wa == 12'd2) begin
                        n_b2 = i_byte;
                    end else begin
                        n_wr = '{en: 1'b1, addr: wa, data: i_byte};
                    end
                    n_filled = wa + 12'd1;
                    if (r_mode == MODE_SECTION) begin
                        if (n_filled == n_size) begin
                            n_filled = '0;
                            n_ready  = 1'b1;
                            n_len    = n_size;
                            n_mode   = MODE_SCAN;
                        end
                    end else if (n_size == 12'd0) begin
                        if (n_filled == 12'd3) begin
                            s = sect_len(n_b1, n_b2);
                            if (!len_ok(s)) begin
                                n_filled = '0;
                                n_mode   = MODE_IGNORE;
                                n_due    = 1'b0;
                            end else begin
                                n_size = s[11:0];
                            end
                        end
                    end else if (n_filled == n_size) begin
                        n_filled = '0;
                        n_ready  = 1'b1;
                        n_len    = n_size;
                        n_mode   = MODE_IGNORE;
                    end
                end
                default: begin
                end
            endcase
        end

        // start of payload after header or adaptation field
        if (bp) begin
            cc_ok = ((r_lastcc + 4'd1) == n_pcc);
            if (n_flags[0]) begin
                n_mode = MODE_POINTER;
            end else if (n_filled == 12'd0) begin
                n_mode = MODE_IGNORE;
            end else if (!cc_ok || (n_size == 12'd0 && n_filled >= 12'd3)) begin
                n_filled = '0;
                n_mode   = MODE_IGNORE;
                n_due    = 1'b0;
            end else begin
                n_mode = MODE_CONT;
                n_due  = 1'b1;
            end
        end

        // last byte of packet
        if (n_pos == 8'(PACKET_BYTES - 1)) begin
            if (n_mode == MODE_SHEAD) begin
                n_b0     = n_shadow[15:8];
                n_filled = 12'd1;
                if (n_pcount == 8'd2) begin
                    n_b1     = n_shadow[7:0];
                    n_filled = 12'd2;
                end
                n_size = '0;
            end else if (n_mode == MODE_PREGION && n_flags[2]) begin
                n_filled = '0;
                n_due    = 1'b0;
            end
            if (n_due) begin
                n_lastcc = n_pcc;
            end
            n_due   = 1'b0;
            n_flags = n_flags & 3'b011;
            n_mode  = MODE_IGNORE;
        end
    end

    assign o_wr    = i_step ? n_wr : '0;
    assign o_ready = n_ready;
    assign o_len   = n_len;
    assign o_b0    = r_b0;
    assign o_b1    = r_b1;
    assign o_b2    = r_b2;

endmodule
